// ===== rtl/core/cldq_pkg.sv =====
`default_nettype none
package cldq_pkg;

  // Fixed field widths
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned ARR_W     = 2;
  localparam int unsigned SP_W      = 16;
  localparam int unsigned LIM_W     = 9;
  localparam int unsigned CNT_OUT_W = 9;
  localparam int unsigned CFG_AW    = 3;
  localparam int unsigned CFG_DW    = 32;

  // Defaults and constants
  localparam int unsigned RING_DEPTH_DEF = 256;
  localparam int unsigned MAX_ARRIVALS   = 3;
  localparam logic [SP_W-1:0]  SP_RESET  = SP_W'(100);
  localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(7);

  // Register index, taken from byte address bit 2
  typedef enum logic {
    REG_SERVICE_PERIOD  = 1'b0,
    REG_IN_FLIGHT_LIMIT = 1'b1
  } cldq_reg_t;

  // One stored group: all requests that arrived in one tick share a stamp
  typedef struct packed {
    logic [TIME_W-1:0] stamp;
    logic [ARR_W-1:0]  cnt;
  } cldq_grp_t;

  // Control from the tick logic to the stamp store
  typedef struct packed {
    logic             push;
    logic [ARR_W-1:0] push_cnt;
    logic             take;
  } cldq_fifo_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/core/cldq_intf.sv =====
`default_nettype none
// Input channel: one item is one tick
interface cldq_in_if;
  logic                         valid;
  logic                         ready;
  logic [cldq_pkg::ARR_W-1:0]   arrivals;
  logic                         dispatch_now;

  modport source (output valid, output arrivals, output dispatch_now, input ready);
  modport sink   (input valid, input arrivals, input dispatch_now, output ready);
endinterface

// Result channel: one item per tick
interface cldq_out_if;
  logic                             valid;
  logic                             ready;
  logic                             done_res;
  logic [cldq_pkg::TIME_W-1:0]      latency_ticks;
  logic [cldq_pkg::CNT_OUT_W-1:0]   pending_count;
  logic [cldq_pkg::CNT_OUT_W-1:0]   in_flight_count;
  logic                             dropped;

  modport source (output valid, output done_res, output latency_ticks,
                  output pending_count, output in_flight_count, output dropped,
                  input ready);
  modport sink   (input valid, input done_res, input latency_ticks,
                  input pending_count, input in_flight_count, input dropped,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/core/cldq_stamp_fifo.sv =====
`default_nettype none
module cldq_stamp_fifo #(
  parameter int unsigned RING_DEPTH = cldq_pkg::RING_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire cldq_pkg::cldq_fifo_ctl_t      ctl,
  input  wire logic [cldq_pkg::TIME_W-1:0]   push_stamp,
  output logic      [cldq_pkg::TIME_W-1:0]   head_stamp
);
  import cldq_pkg::*;

  localparam int unsigned PTR_W = $clog2(RING_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

  cldq_grp_t        mem [RING_DEPTH];
  cldq_grp_t        wr_grp;
  cldq_grp_t        rd_q_r;
  cldq_grp_t        byp_q_r;
  cldq_grp_t        head;
  logic             byp_r;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] hd_ptr_r, hd_ptr_nxt;
  logic [ARR_W-1:0] off_r, off_nxt;
  logic             last_of_grp;

  assign wr_grp = '{stamp: push_stamp, cnt: ctl.push_cnt};

  // Head group comes from memory, or from the write made at the same edge
  assign head       = byp_r ? byp_q_r : rd_q_r;
  assign head_stamp = head.stamp;

  // Consume one request; drop the head group once all of it is consumed
  assign last_of_grp = (off_r + ARR_W'(1)) == head.cnt;

  always_comb begin
    hd_ptr_nxt = hd_ptr_r;
    off_nxt    = off_r;
    if (ctl.take) begin
      if (last_of_grp) begin
        hd_ptr_nxt = (hd_ptr_r == PTR_LAST) ? '0 : hd_ptr_r + PTR_W'(1);
        off_nxt    = '0;
      end else begin
        off_nxt = off_r + ARR_W'(1);
      end
    end
  end

  // Advance write pointer on push
  assign wr_ptr_nxt = ctl.push ? ((wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1))
                               : wr_ptr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      hd_ptr_r <= '0;
      off_r    <= '0;
      byp_r    <= 1'b0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      hd_ptr_r <= hd_ptr_nxt;
      off_r    <= off_nxt;
      byp_r    <= ctl.push && (wr_ptr_r == hd_ptr_nxt);
    end
  end

  // Group memory: one write, one registered read at the next head
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[wr_ptr_r] <= wr_grp;
    end
    rd_q_r  <= mem[hd_ptr_nxt];
    byp_q_r <= wr_grp;
  end

endmodule
`default_nettype wire

// ===== rtl/core/credit_limited_dispatch_queue.sv =====
// An accepted item passes through the input register, then the result register.
// Throughput: one item per cycle; in_ch.ready only drops while the result
// register is full and out_ch.ready is low.
// The arrival store keeps one entry per tick with arrivals, read ahead at the next head.
// Reset: synchronous, active low; clears time, counts and pointers and loads
// service_period 100 and in_flight_limit 7. No clearing pass is needed.
`default_nettype none
module credit_limited_dispatch_queue #(
  parameter int unsigned RING_DEPTH = cldq_pkg::RING_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  cldq_in_if.sink                            in_ch,
  cldq_out_if.source                         out_ch,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [cldq_pkg::CFG_AW-1:0]   paddr,
  input  wire logic [cldq_pkg::CFG_DW-1:0]   pwdata,
  output logic      [cldq_pkg::CFG_DW-1:0]   prdata,
  output logic                               pready
);
  import cldq_pkg::*;

  localparam int unsigned CNT_W = $clog2(RING_DEPTH + 1);
  localparam int unsigned CMP_W = ((CNT_W > LIM_W) ? CNT_W : LIM_W) + 1;
  localparam int unsigned TOT_W = CNT_W + 1;

  // Configuration registers
  logic [SP_W-1:0]  sp_r;
  logic [LIM_W-1:0] lim_r;
  cldq_reg_t        reg_sel;
  logic             cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = cldq_reg_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    case (reg_sel)
      REG_SERVICE_PERIOD:  prdata = CFG_DW'(sp_r);
      REG_IN_FLIGHT_LIMIT: prdata = CFG_DW'(lim_r);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r  <= SP_RESET;
      lim_r <= LIM_RESET;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_SERVICE_PERIOD:  sp_r  <= pwdata[SP_W-1:0];
        REG_IN_FLIGHT_LIMIT: lim_r <= pwdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register and result register handshake
  logic             s1_valid_r;
  logic [ARR_W-1:0] s1_arr_r;
  logic             s1_disp_r;
  logic             s1_fire;
  logic             out_valid_r;

  assign s1_fire     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_arr_r  <= in_ch.arrivals;
      s1_disp_r <= in_ch.dispatch_now;
    end
  end

  // Tick state
  logic [TIME_W-1:0] now_r, nc_r, nc_nxt;
  logic [CNT_W-1:0]  exec_r, exec_nxt;
  logic [CNT_W-1:0]  wait_r, wait_nxt;
  logic [TIME_W-1:0] head_stamp;
  logic [TIME_W-1:0] since_due;
  logic              due;
  logic [CNT_W-1:0]  exec_a, wait_a;
  logic [TOT_W-1:0]  tot, free;
  logic [ARR_W-1:0]  arr_c, acc;
  logic              drop;
  logic              disp_ok;
  logic [CMP_W-1:0]  room, n_mv;
  logic [TIME_W-1:0] lat;
  cldq_fifo_ctl_t    fctl;

  // Completion: oldest in-flight request finishes when its time is reached
  assign since_due = now_r - nc_r;
  assign due       = (exec_r != '0) && !since_due[TIME_W-1];
  assign exec_a    = exec_r - CNT_W'(due);
  assign lat       = due ? (now_r - head_stamp) : '0;

  // Arrivals: clamp, then take as many as the ring has room for
  assign arr_c = (32'(s1_arr_r) > MAX_ARRIVALS) ? ARR_W'(MAX_ARRIVALS) : s1_arr_r;
  assign tot   = TOT_W'(exec_a) + TOT_W'(wait_r);
  assign free  = TOT_W'(RING_DEPTH) - tot;
  assign drop  = TOT_W'(arr_c) > free;
  assign acc   = drop ? free[ARR_W-1:0] : arr_c;
  assign wait_a = wait_r + CNT_W'(acc);

  // Dispatch: move pending requests to in flight up to the limit
  assign disp_ok = s1_disp_r && (wait_a != '0) && (CMP_W'(exec_a) < CMP_W'(lim_r));
  assign room    = CMP_W'(lim_r) - CMP_W'(exec_a);
  assign n_mv    = (CMP_W'(wait_a) < room) ? CMP_W'(wait_a) : room;

  always_comb begin
    exec_nxt = exec_a;
    wait_nxt = wait_a;
    nc_nxt   = due ? nc_r + TIME_W'(sp_r) : nc_r;
    if (disp_ok) begin
      exec_nxt = exec_a + n_mv[CNT_W-1:0];
      wait_nxt = wait_a - n_mv[CNT_W-1:0];
      if (exec_a == '0) begin
        nc_nxt = now_r + TIME_W'(sp_r);
      end
    end
  end

  // Drive the stamp store only when the tick commits
  assign fctl.push     = s1_fire && (acc != '0);
  assign fctl.push_cnt = acc;
  assign fctl.take     = s1_fire && due;

  cldq_stamp_fifo #(
    .RING_DEPTH (RING_DEPTH)
  ) u_stamp_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (fctl),
    .push_stamp (now_r),
    .head_stamp (head_stamp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r  <= '0;
      nc_r   <= '0;
      exec_r <= '0;
      wait_r <= '0;
    end else if (s1_fire) begin
      now_r  <= now_r + TIME_W'(1);
      nc_r   <= nc_nxt;
      exec_r <= exec_nxt;
      wait_r <= wait_nxt;
    end
  end

  // Result register
  logic [CNT_W+CNT_OUT_W-1:0] pend_ext, infl_ext;
  logic                       done_r, drop_r;
  logic [TIME_W-1:0]          lat_r;
  logic [CNT_OUT_W-1:0]       pend_r, infl_r;

  assign pend_ext = {{CNT_OUT_W{1'b0}}, wait_nxt};
  assign infl_ext = {{CNT_OUT_W{1'b0}}, exec_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      done_r <= due;
      lat_r  <= lat;
      pend_r <= pend_ext[CNT_OUT_W-1:0];
      infl_r <= infl_ext[CNT_OUT_W-1:0];
      drop_r <= drop;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.done_res        = done_r;
  assign out_ch.latency_ticks   = lat_r;
  assign out_ch.pending_count   = pend_r;
  assign out_ch.in_flight_count = infl_r;
  assign out_ch.dropped         = drop_r;

endmodule
`default_nettype wire
